/* src/pf_pkg.sv */
// Shared types, codes and helper functions for the Playfair digraph cipher.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package pf_pkg;

  // Depth of the pair queue between the front and back parts.
  localparam int unsigned PF_QDEPTH = 4;

  // Letter indices with A = 0.
  localparam logic [4:0] LETTER_I = 5'd8;
  localparam logic [4:0] LETTER_J = 5'd9;
  localparam logic [4:0] LETTER_X = 5'd23;
  localparam logic [4:0] LETTER_Z = 5'd25;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_ROWS01 = 2'd1,
    REG_ROWS23 = 2'd2,
    REG_ROW4   = 2'd3
  } pf_reg_e;

  // Whole key square: cell k (row * 5 + column) sits at bits 5k+4..5k.
  typedef logic [124:0] pf_square_t;

  // One digraph on its way from the front to the back part.
  typedef struct packed {
    logic [4:0] first;
    logic [4:0] second;
    logic       last;
  } pf_pair_t;

  // Queue status seen by both neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } pf_qstat_t;

  // Letter index held in the square at a given row and column.
  function automatic logic [4:0] pf_cell(input pf_square_t sq, input logic [2:0] r,
                                         input logic [2:0] c);
    logic [6:0] k;
    k = {4'b0, r} * 7'd5 + {4'b0, c};
    return sq[k * 7'd5 +: 5];
  endfunction

  // One step around the square: forward when enciphering, backward when deciphering.
  function automatic logic [2:0] pf_step(input logic [2:0] x, input logic dec);
    logic [2:0] y;
    if (dec) begin
      y = (x == 3'd0) ? 3'd4 : 3'(x - 3'd1);
    end else begin
      y = (x == 3'd4) ? 3'd0 : 3'(x + 3'd1);
    end
    return y;
  endfunction

  // Letter index to upper-case ASCII; codes past Z come out as Z.
  function automatic logic [6:0] pf_ascii(input logic [4:0] code);
    return (code > LETTER_Z) ? 7'd90 : 7'(7'd65 + {2'b0, code});
  endfunction

endpackage

`default_nettype wire

/* src/playfair_digraph_cipher_top.sv */
// Top level of the Playfair digraph cipher: configuration registers and wiring.
// Depends on pf_pkg, pf_front, pf_queue and pf_back.
//
//   Channel   Direction  Handshake                   Payload
//   input     in         in_valid_i / in_stall_o     char_in_i, end_of_message_i
//   output    out        out_valid_o / out_stall_i   letter_out_o, last_of_message_o
//   config    in         APB psel/penable/pready     paddr, pwdata, prdata
//
// Each accepted byte yields zero, one or two digraphs.
// The back part issues one letter per cycle while out_stall_i is low and pairs wait.
// A pair goes from the front's hold buffer through the queue and two stages.
// Reset clears the pairing state, queue and pipeline and loads the default square.
// The front stalls until its held pairs are pushed; an output stall fills the queue.
`timescale 1ns / 1ps
`default_nettype none

module playfair_digraph_cipher_top import pf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  char_in_i,
  input  wire logic        end_of_message_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [6:0]       letter_out_o,
  output logic             last_of_message_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic        mode_q;
  logic [49:0] rows01_q, rows23_q;
  logic [24:0] row4_q;
  pf_reg_e     reg_sel;
  logic        cfg_wr;

  pf_square_t  square;
  logic        push, pop;
  pf_pair_t    push_data, pop_data;
  pf_qstat_t   qstat;

  // Configuration registers, one per 8-byte slot.
  assign pready  = 1'b1;
  assign reg_sel = pf_reg_e'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      rows01_q <= 50'd71493435544068;
      rows23_q <= 50'd652539056068771;
      row4_q   <= 25'd27024051;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_MODE:   mode_q   <= pwdata[0];
        REG_ROWS01: rows01_q <= pwdata[49:0];
        REG_ROWS23: rows23_q <= pwdata[49:0];
        REG_ROW4:   row4_q   <= pwdata[24:0];
        default:    mode_q   <= mode_q;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_sel)
      REG_MODE:   prdata = {63'd0, mode_q};
      REG_ROWS01: prdata = {14'd0, rows01_q};
      REG_ROWS23: prdata = {14'd0, rows23_q};
      REG_ROW4:   prdata = {39'd0, row4_q};
      default:    prdata = 64'd0;
    endcase
  end

  assign square = {row4_q, rows23_q, rows01_q};

  pf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .mode_i           (mode_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .char_in_i        (char_in_i),
    .end_of_message_i (end_of_message_i),
    .push_o           (push),
    .push_data_o      (push_data),
    .qstat_i          (qstat)
  );

  pf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .pop_i  (pop),
    .data_o (pop_data),
    .stat_o (qstat)
  );

  pf_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .mode_i            (mode_q),
    .square_i          (square),
    .qstat_i           (qstat),
    .pair_i            (pop_data),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .letter_out_o      (letter_out_o),
    .last_of_message_o (last_of_message_o)
  );

  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && qstat.full))
    else $error("pair pushed into a full queue");

  // The back never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && qstat.empty))
    else $error("pair popped from an empty queue");

  // Every letter shown is an upper-case ASCII letter.
  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (letter_out_o >= 7'd65 && letter_out_o <= 7'd90))
    else $error("output letter out of range");

  // A message end is flagged only on the second letter of a digraph, so a letter
  // was already on offer in the cycle before.
  a_last_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_message_o) |-> $past(out_valid_o))
    else $error("end flag on the first letter of a digraph");

endmodule

`default_nettype wire

/* src/pf_front.sv */
// Front part: normalizes message bytes, inserts fillers and forms digraphs.
// Depends on pf_pkg; feeds pf_queue one pair per cycle while the queue is not full.
`timescale 1ns / 1ps
`default_nettype none

module pf_front import pf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      mode_i,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire logic [7:0] char_in_i,
  input  wire logic      end_of_message_i,
  output logic           push_o,
  output pf_pair_t       push_data_o,
  input  wire pf_qstat_t qstat_i
);

  logic [4:0] pend_q, pend_d, prev_q, prev_d;
  logic       pend_v_q, pend_v_d, prev_v_q, prev_v_d;
  logic [1:0] cnt_q, cnt_d;
  pf_pair_t   h0_q, h0_d, h1_q, h1_d;

  logic       accept;
  logic       push;
  logic [1:0] n_new;
  pf_pair_t   pr [2];

  // Pairs held for the queue drain one per cycle while the queue is not full.
  assign push        = (cnt_q != 2'd0) && !qstat_i.full;
  assign push_o      = push;
  assign push_data_o = h0_q;
  assign in_stall_o  = !((cnt_q == 2'd0) || ((cnt_q == 2'd1) && push));
  assign accept      = in_valid_i && !in_stall_o;

  // Normalize the byte and run up to three letters through the pairing logic.
  always_comb begin
    logic [7:0] ch;
    logic       have;
    logic [4:0] code;
    logic       pv;
    logic [4:0] pl;
    logic       en;
    logic [4:0] let_v;
    ch    = char_in_i;
    have  = 1'b0;
    code  = 5'd0;
    pv    = pend_v_q;
    pl    = pend_q;
    n_new = 2'd0;
    pr[0] = '0;
    pr[1] = '0;
    if (ch >= 8'd97 && ch <= 8'd122) begin
      ch = 8'(ch - 8'd32);
    end
    if (ch >= 8'd65 && ch <= 8'd90) begin
      code = 5'(ch - 8'd65);
      if (code == LETTER_J) begin
        code = LETTER_I;
      end
      have = 1'b1;
    end
    // Slots: filler X, the letter itself, then the end-of-message pad.
    for (int i = 0; i < 3; i++) begin
      en    = 1'b0;
      let_v = LETTER_X;
      case (i)
        0: begin
          en = have && !mode_i && prev_v_q && (prev_q == code);
        end
        1: begin
          en    = have;
          let_v = code;
        end
        default: begin
          en = end_of_message_i && pv;
        end
      endcase
      if (en) begin
        if (pv) begin
          pr[n_new[0]].first  = pl;
          pr[n_new[0]].second = let_v;
          n_new = 2'(n_new + 2'd1);
          pv    = 1'b0;
          pl    = 5'd0;
        end else begin
          pl = let_v;
          pv = 1'b1;
        end
      end
    end
    if (end_of_message_i && (n_new != 2'd0)) begin
      pr[n_new[1]].last = 1'b1;
    end
    // Next pairing state.
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    prev_d   = prev_q;
    prev_v_d = prev_v_q;
    if (accept) begin
      if (end_of_message_i) begin
        pend_d   = 5'd0;
        pend_v_d = 1'b0;
        prev_d   = 5'd0;
        prev_v_d = 1'b0;
      end else begin
        pend_d   = pl;
        pend_v_d = pv;
        if (have) begin
          prev_d   = code;
          prev_v_d = 1'b1;
        end
      end
    end
  end

  // Hold buffer for the pairs of the latest transaction.
  always_comb begin
    cnt_d = cnt_q;
    h0_d  = h0_q;
    h1_d  = h1_q;
    if (accept) begin
      cnt_d = n_new;
      h0_d  = pr[0];
      h1_d  = pr[1];
    end else if (push) begin
      cnt_d = 2'(cnt_q - 2'd1);
      h0_d  = h1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 5'd0;
      pend_v_q <= 1'b0;
      prev_q   <= 5'd0;
      prev_v_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      pend_q   <= pend_d;
      pend_v_q <= pend_v_d;
      prev_q   <= prev_d;
      prev_v_q <= prev_v_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h0_q <= h0_d;
    h1_q <= h1_d;
  end

endmodule

`default_nettype wire

/* src/pf_queue.sv */
// Short queue of digraphs between the front and back parts.
// Depends on pf_pkg for the pair type and depth.
`timescale 1ns / 1ps
`default_nettype none

module pf_queue import pf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire pf_pair_t data_i,
  input  wire logic     pop_i,
  output pf_pair_t      data_o,
  output pf_qstat_t     stat_o
);

  localparam int unsigned PtrW = (PF_QDEPTH > 1) ? $clog2(PF_QDEPTH) : 1;
  localparam int unsigned CntW = $clog2(PF_QDEPTH + 1);

  pf_pair_t            mem_q [PF_QDEPTH];
  logic [PtrW-1:0]     wptr_q, rptr_q;
  logic [CntW-1:0]     cnt_q;

  assign stat_o.full  = (cnt_q == CntW'(PF_QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign data_o       = mem_q[rptr_q];

  // Storage written at the tail.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(PF_QDEPTH - 1)) ? '0 : PtrW'(wptr_q + 1'b1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(PF_QDEPTH - 1)) ? '0 : PtrW'(rptr_q + 1'b1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= CntW'(cnt_q + 1'b1);
      end else if (pop_i && !push_i) begin
        cnt_q <= CntW'(cnt_q - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

/* src/pf_back.sv */
// Back part: locates each digraph in the key square and emits two letters.
// Depends on pf_pkg; pops pairs from pf_queue.
`timescale 1ns / 1ps
`default_nettype none

module pf_back import pf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       mode_i,
  input  wire pf_square_t square_i,
  input  wire pf_qstat_t  qstat_i,
  input  wire pf_pair_t   pair_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [6:0]      letter_out_o,
  output logic            last_of_message_o
);

  // Stage one: square positions of both letters.
  logic       s1_v_q;
  logic [2:0] r1_q, c1_q, r2_q, c2_q;
  logic       s1_last_q;
  // Stage two: the two output letters, sent first then second.
  logic       s2_v_q, sel_q;
  logic [6:0] la_q, lb_q;
  logic       s2_last_q;

  logic       out_fire, s2_load, s1_load;
  logic [2:0] r1_d, c1_d, r2_d, c2_d;
  logic [2:0] ra, ca, rb, cb;

  // Position of a letter; the last match in row-major order wins, absent means 0,0.
  function automatic logic [5:0] locate(input pf_square_t sq, input logic [4:0] letter);
    logic [2:0] rr, cc;
    rr = 3'd0;
    cc = 3'd0;
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        if (sq[(r * 5 + c) * 5 +: 5] == letter) begin
          rr = 3'(r);
          cc = 3'(c);
        end
      end
    end
    return {rr, cc};
  endfunction

  assign out_fire = s2_v_q && !out_stall_i;
  assign s2_load  = s1_v_q && (!s2_v_q || (sel_q && out_fire));
  assign s1_load  = !qstat_i.empty && (!s1_v_q || s2_load);
  assign pop_o    = s1_load;

  assign out_valid_o       = s2_v_q;
  assign letter_out_o      = sel_q ? lb_q : la_q;
  assign last_of_message_o = sel_q && s2_last_q;

  assign {r1_d, c1_d} = locate(square_i, pair_i.first);
  assign {r2_d, c2_d} = locate(square_i, pair_i.second);

  // Playfair rules: same row, same column, or rectangle corners.
  always_comb begin
    if (r1_q == r2_q) begin
      ra = r1_q;
      ca = pf_step(c1_q, mode_i);
      rb = r1_q;
      cb = pf_step(c2_q, mode_i);
    end else if (c1_q == c2_q) begin
      ra = pf_step(r1_q, mode_i);
      ca = c1_q;
      rb = pf_step(r2_q, mode_i);
      cb = c1_q;
    end else begin
      ra = r1_q;
      ca = c2_q;
      rb = r2_q;
      cb = c1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      sel_q  <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_v_q <= 1'b1;
      end else if (s2_load) begin
        s1_v_q <= 1'b0;
      end
      if (s2_load) begin
        s2_v_q <= 1'b1;
        sel_q  <= 1'b0;
      end else if (out_fire) begin
        if (sel_q) begin
          s2_v_q <= 1'b0;
          sel_q  <= 1'b0;
        end else begin
          sel_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      r1_q      <= r1_d;
      c1_q      <= c1_d;
      r2_q      <= r2_d;
      c2_q      <= c2_d;
      s1_last_q <= pair_i.last;
    end
    if (s2_load) begin
      la_q      <= pf_ascii(pf_cell(square_i, ra, ca));
      lb_q      <= pf_ascii(pf_cell(square_i, rb, cb));
      s2_last_q <= s1_last_q;
    end
  end

endmodule

`default_nettype wire
